[design/tld_pkg.sv]
package tld_pkg;

    localparam int RING_DEPTH = 2048;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int PTR_W      = RING_AW + 1;
    localparam int CNT_W      = 12;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CTRL_OFS = 8'd64;

    localparam logic [5:0]  MODE_RST = 6'd61;
    localparam logic [23:0] SIGC_RST = 24'h1A1C03;
    localparam logic [23:0] EDIT_RST = 24'h04157F;

    localparam int M_ICRNL  = 0;
    localparam int M_INLCR  = 1;
    localparam int M_ONLCR  = 2;
    localparam int M_ISIG   = 3;
    localparam int M_ICANON = 4;
    localparam int M_ECHO   = 5;

    typedef enum logic [2:0] {
        K_TYPED  = 3'd0,
        K_OUTPUT = 3'd1,
        K_PREAD  = 3'd2,
        K_UREAD  = 3'd3,
        K_FLUSH  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_SIGC = 2'd1,
        REG_EDIT = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        IRD_TAIL   = 2'd0,
        IRD_NEWEST = 2'd1,
        IRD_SCAN   = 2'd2
    } t_in_rd;

    typedef enum logic [2:0] {
        OB_DATA  = 3'd0,
        OB_CR    = 3'd1,
        OB_NL    = 3'd2,
        OB_BS    = 3'd3,
        OB_SP    = 3'd4,
        OB_CARET = 3'd5,
        OB_CTRL  = 3'd6
    } t_obyte;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PUSH_CR,
        ST_PUSH_B,
        ST_SIG_CARET,
        ST_SIG_CTRL,
        ST_SIG_CR,
        ST_SIG_NL,
        ST_ERASE_RD,
        ST_ERASE_CHK,
        ST_EB1,
        ST_EB2,
        ST_EB3,
        ST_POP_IN,
        ST_POP_OUT,
        ST_FINISH,
        ST_SCAN_CHK,
        ST_SCAN_ACC
    } t_state;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             read_valid;
        logic             eof_marker;
        logic [1:0]       signal_code;
        logic             line_avail;
        logic [CNT_W-1:0] input_count;
        logic [CNT_W-1:0] output_count;
    } t_result;

    typedef struct packed {
        logic   start;
        logic   set_sig;
        logic   push_in;
        logic   push_out;
        t_obyte out_sel;
        logic   in_rd;
        t_in_rd in_rd_sel;
        logic   out_rd;
        logic   erase;
        logic   pop_in;
        logic   pop_out;
        logic   flush;
        logic   finish;
        logic   scan_start;
        logic   scan_acc;
        logic   scan_done;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       sig_hit;
        logic       echo;
        logic       onlcr_nl;
        logic       erase_hit;
        logic       kill_hit;
        logic       in_empty;
        logic       read_ok;
        logic       out_empty;
        logic       newest_nl;
        logic       out_free;
        logic       rescan;
        logic       scan_at_head;
    } t_stat;

    // newline or the enabled end-of-file character
    function automatic logic is_term(input logic [7:0] b, input logic [7:0] eofc);
        is_term = (b == CH_NL) || ((eofc != 8'd0) && (b == eofc));
    endfunction

endpackage

[design/tld_ctrl.sv]
module tld_ctrl
    import tld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.out_sel   = OB_DATA;
        o_cmd.in_rd_sel = IRD_TAIL;
        o_in_stall = (r_state != ST_IDLE) || i_stat.rescan;
        case (r_state)
            ST_IDLE: begin
                if (i_stat.rescan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = ST_SCAN_CHK;
                end else if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_stat.kind)
                    K_TYPED: begin
                        if (i_stat.sig_hit) begin
                            o_cmd.set_sig = 1'b1;
                            n_state = i_stat.echo ? ST_SIG_CARET : ST_FINISH;
                        end else if (i_stat.erase_hit || i_stat.kill_hit) begin
                            n_state = ST_ERASE_RD;
                        end else begin
                            o_cmd.push_in = 1'b1;
                            if (!i_stat.echo) begin
                                n_state = ST_FINISH;
                            end else if (i_stat.onlcr_nl) begin
                                n_state = ST_PUSH_CR;
                            end else begin
                                n_state = ST_PUSH_B;
                            end
                        end
                    end
                    K_OUTPUT: begin
                        n_state = i_stat.onlcr_nl ? ST_PUSH_CR : ST_PUSH_B;
                    end
                    K_PREAD: begin
                        if (i_stat.read_ok) begin
                            o_cmd.in_rd = 1'b1;
                            o_cmd.in_rd_sel = IRD_TAIL;
                            n_state = ST_POP_IN;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                    K_UREAD: begin
                        if (!i_stat.out_empty) begin
                            o_cmd.out_rd = 1'b1;
                            n_state = ST_POP_OUT;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                    K_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        n_state = ST_FINISH;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_PUSH_CR: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_CR;
                n_state = ST_PUSH_B;
            end
            ST_PUSH_B: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_DATA;
                n_state = ST_FINISH;
            end
            ST_SIG_CARET: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_CARET;
                n_state = ST_SIG_CTRL;
            end
            ST_SIG_CTRL: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_CTRL;
                n_state = ST_SIG_CR;
            end
            ST_SIG_CR: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_CR;
                n_state = ST_SIG_NL;
            end
            ST_SIG_NL: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_NL;
                n_state = ST_FINISH;
            end
            ST_ERASE_RD: begin
                if (i_stat.in_empty) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.in_rd = 1'b1;
                    o_cmd.in_rd_sel = IRD_NEWEST;
                    n_state = ST_ERASE_CHK;
                end
            end
            ST_ERASE_CHK: begin
                // never erase back past a newline
                if (i_stat.newest_nl) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.erase = 1'b1;
                    if (i_stat.echo) begin
                        n_state = ST_EB1;
                    end else begin
                        n_state = i_stat.kill_hit ? ST_ERASE_RD : ST_FINISH;
                    end
                end
            end
            ST_EB1: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_BS;
                n_state = ST_EB2;
            end
            ST_EB2: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_SP;
                n_state = ST_EB3;
            end
            ST_EB3: begin
                o_cmd.push_out = 1'b1;
                o_cmd.out_sel = OB_BS;
                n_state = i_stat.kill_hit ? ST_ERASE_RD : ST_FINISH;
            end
            ST_POP_IN: begin
                o_cmd.pop_in = 1'b1;
                n_state = ST_FINISH;
            end
            ST_POP_OUT: begin
                o_cmd.pop_out = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_CHK: begin
                if (i_stat.scan_at_head) begin
                    o_cmd.scan_done = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.in_rd = 1'b1;
                    o_cmd.in_rd_sel = IRD_SCAN;
                    n_state = ST_SCAN_ACC;
                end
            end
            ST_SCAN_ACC: begin
                o_cmd.scan_acc = 1'b1;
                n_state = ST_SCAN_CHK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/tld_dpath.sv]
module tld_dpath
    import tld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_item       i_in,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_result     o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]  r_mode;
    logic [23:0] r_sigc;
    logic [23:0] r_editc;
    logic        r_rescan;

    logic [2:0]  r_kind;
    logic [7:0]  r_b;

    logic [PTR_W-1:0] r_in_head, r_in_tail, r_out_head, r_out_tail;
    logic [PTR_W-1:0] r_term, r_scan_ptr, r_scan_cnt;

    logic [7:0] r_in_ring  [RING_DEPTH];
    logic [7:0] r_out_ring [RING_DEPTH];
    logic [7:0] r_in_q, r_out_q;

    logic [7:0] r_rbyte;
    logic       r_rvalid, r_eof;
    logic [1:0] r_sig;

    t_result r_res;
    logic    r_res_valid;

    logic             cfg_wr;
    t_reg             cfg_idx;
    logic [7:0]       b_x, eofc, erc, klc, s0, s1, s2, ob;
    logic [1:0]       sig;
    logic [PTR_W-1:0] in_fill, out_fill, in_newest;
    logic             in_full, out_full, canon, line_rdy;
    logic [RING_AW-1:0] in_raddr;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_MODE: prdata = {26'd0, r_mode};
            REG_SIGC: prdata = {8'd0, r_sigc};
            REG_EDIT: prdata = {8'd0, r_editc};
            default:  prdata = 32'd0;
        endcase
    end

    assign s0    = r_sigc[7:0];
    assign s1    = r_sigc[15:8];
    assign s2    = r_sigc[23:16];
    assign erc   = r_editc[7:0];
    assign klc   = r_editc[15:8];
    assign eofc  = r_editc[23:16];
    assign canon = r_mode[M_ICANON];

    // input translation applied at accept, typed bytes only
    always_comb begin
        b_x = i_in.data_byte;
        if (i_in.kind == K_TYPED) begin
            if (r_mode[M_ICRNL] && (i_in.data_byte == CH_CR)) begin
                b_x = CH_NL;
            end else if (r_mode[M_INLCR] && (i_in.data_byte == CH_NL)) begin
                b_x = CH_CR;
            end
        end
    end

    always_comb begin
        if ((s0 != 8'd0) && (r_b == s0)) begin
            sig = 2'd1;
        end else if ((s1 != 8'd0) && (r_b == s1)) begin
            sig = 2'd2;
        end else if ((s2 != 8'd0) && (r_b == s2)) begin
            sig = 2'd3;
        end else begin
            sig = 2'd0;
        end
    end

    assign in_fill   = r_in_head - r_in_tail;
    assign out_fill  = r_out_head - r_out_tail;
    assign in_full   = in_fill >= PTR_W'(RING_DEPTH);
    assign out_full  = out_fill >= PTR_W'(RING_DEPTH);
    assign in_newest = r_in_head - PTR_W'(1);
    assign line_rdy  = canon ? (r_term != '0) : (in_fill != '0);

    always_comb begin
        case (i_cmd.out_sel)
            OB_DATA:  ob = r_b;
            OB_CR:    ob = CH_CR;
            OB_NL:    ob = CH_NL;
            OB_BS:    ob = CH_BS;
            OB_SP:    ob = CH_SP;
            OB_CARET: ob = CH_CARET;
            OB_CTRL:  ob = r_b + CTRL_OFS;
            default:  ob = r_b;
        endcase
    end

    always_comb begin
        case (i_cmd.in_rd_sel)
            IRD_TAIL:   in_raddr = r_in_tail[RING_AW-1:0];
            IRD_NEWEST: in_raddr = in_newest[RING_AW-1:0];
            IRD_SCAN:   in_raddr = r_scan_ptr[RING_AW-1:0];
            default:    in_raddr = r_in_tail[RING_AW-1:0];
        endcase
    end

    always_comb begin
        o_stat.kind         = r_kind;
        o_stat.sig_hit      = r_mode[M_ISIG] && (sig != 2'd0);
        o_stat.echo         = r_mode[M_ECHO];
        o_stat.onlcr_nl     = r_mode[M_ONLCR] && (r_b == CH_NL);
        o_stat.erase_hit    = canon && (((erc != 8'd0) && (r_b == erc)) || (r_b == CH_BS));
        o_stat.kill_hit     = canon && (klc != 8'd0) && (r_b == klc) && !o_stat.erase_hit;
        o_stat.in_empty     = (in_fill == '0);
        o_stat.read_ok      = (in_fill != '0) && (!canon || (r_term != '0));
        o_stat.out_empty    = (out_fill == '0);
        o_stat.newest_nl    = (r_in_q == CH_NL);
        o_stat.out_free     = !r_res_valid || !i_res_stall;
        o_stat.rescan       = r_rescan || (cfg_wr && (cfg_idx == REG_EDIT));
        o_stat.scan_at_head = (r_scan_ptr == r_in_head);
    end

    // ring storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_in && !in_full) begin
            r_in_ring[r_in_head[RING_AW-1:0]] <= r_b;
        end
        if (i_cmd.in_rd) begin
            r_in_q <= r_in_ring[in_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_out && !out_full) begin
            r_out_ring[r_out_head[RING_AW-1:0]] <= ob;
        end
        if (i_cmd.out_rd) begin
            r_out_q <= r_out_ring[r_out_tail[RING_AW-1:0]];
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind   <= i_in.kind;
            r_b      <= b_x;
            r_rbyte  <= 8'd0;
            r_rvalid <= 1'b0;
            r_eof    <= 1'b0;
            r_sig    <= 2'd0;
        end else begin
            if (i_cmd.set_sig) begin
                r_sig <= sig;
            end
            if (i_cmd.pop_in) begin
                if (canon && (eofc != 8'd0) && (r_in_q == eofc)) begin
                    r_eof <= 1'b1;
                end else begin
                    r_rbyte  <= r_in_q;
                    r_rvalid <= 1'b1;
                end
            end
            if (i_cmd.pop_out) begin
                r_rbyte  <= r_out_q;
                r_rvalid <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_res.read_byte    <= r_rbyte;
            r_res.read_valid   <= r_rvalid;
            r_res.eof_marker   <= r_eof;
            r_res.signal_code  <= r_sig;
            r_res.line_avail   <= line_rdy;
            r_res.input_count  <= CNT_W'(in_fill);
            r_res.output_count <= CNT_W'(out_fill);
        end
        if (i_cmd.scan_start) begin
            r_scan_cnt <= '0;
        end else if (i_cmd.scan_acc && is_term(r_in_q, eofc)) begin
            r_scan_cnt <= r_scan_cnt + PTR_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RST;
            r_sigc      <= SIGC_RST;
            r_editc     <= EDIT_RST;
            r_rescan    <= 1'b0;
            r_in_head   <= '0;
            r_in_tail   <= '0;
            r_out_head  <= '0;
            r_out_tail  <= '0;
            r_term      <= '0;
            r_scan_ptr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_MODE: r_mode  <= pwdata[5:0];
                    REG_SIGC: r_sigc  <= pwdata[23:0];
                    REG_EDIT: r_editc <= pwdata[23:0];
                    default: ;
                endcase
            end
            // a new end-of-file character changes which stored bytes end a line
            if (cfg_wr && (cfg_idx == REG_EDIT)) begin
                r_rescan <= 1'b1;
            end else if (i_cmd.scan_start) begin
                r_rescan <= 1'b0;
            end

            if (i_cmd.push_in && !in_full) begin
                r_in_head <= r_in_head + PTR_W'(1);
                if (is_term(r_b, eofc)) begin
                    r_term <= r_term + PTR_W'(1);
                end
            end else if (i_cmd.erase) begin
                r_in_head <= in_newest;
                if (is_term(r_in_q, eofc)) begin
                    r_term <= r_term - PTR_W'(1);
                end
            end else if (i_cmd.pop_in) begin
                r_in_tail <= r_in_tail + PTR_W'(1);
                if (is_term(r_in_q, eofc)) begin
                    r_term <= r_term - PTR_W'(1);
                end
            end else if (i_cmd.flush) begin
                r_in_tail <= r_in_head;
                r_term    <= '0;
            end else if (i_cmd.scan_done) begin
                r_term <= r_scan_cnt;
            end

            if (i_cmd.push_out && !out_full) begin
                r_out_head <= r_out_head + PTR_W'(1);
            end
            if (i_cmd.pop_out) begin
                r_out_tail <= r_out_tail + PTR_W'(1);
            end

            if (i_cmd.scan_start) begin
                r_scan_ptr <= r_in_tail;
            end else if (i_cmd.scan_acc) begin
                r_scan_ptr <= r_scan_ptr + PTR_W'(1);
            end

            if (i_cmd.finish) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTH
    a_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fill <= PTR_W'(RING_DEPTH))
        else $error("input ring fill beyond depth");
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fill <= PTR_W'(RING_DEPTH))
        else $error("output ring fill beyond depth");
    a_term_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_term <= in_fill)
        else $error("line terminator count exceeds input fill");
    a_res_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(i_cmd.finish))
        else $error("result raised without finish");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_res_valid || !i_res_stall))
        else $error("result overwritten while held");
`endif

endmodule

[design/terminal_line_discipline.sv]
// Terminal line discipline with an input ring toward the program and an output
// ring toward the user side, each 2048 bytes in single-port-read memories. One
// transaction is taken at a time and yields exactly one result; a result held
// at the output does not block acceptance of the next input, but that
// transaction waits to finish until the result is taken. Erase and kill with
// echo take one input ring read plus three echo writes per removed byte, the
// output ring taking one write a cycle. A write of the edit character register
// starts a recount of line terminators over the queued input, during which no
// input transaction is taken.
module terminal_line_discipline
    import tld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_item       i_in,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_result     o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd  cmd;
    t_stat stat;

    tld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tld_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

endmodule
